// File: hw/rtl/ztu_pkg.sv
// Shared types, constants and calendar functions for the zoned time to UTC converter.
`timescale 1ns / 1ps

package ztu_pkg;

  // Zone sign codes. The unused code 3 behaves like a positive offset.
  localparam logic [1:0] ZONE_UTC   = 2'd0;
  localparam logic [1:0] ZONE_MINUS = 2'd2;

  localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;

  // Divisibility by 25 on a 16-bit year: multiply by the inverse of 25 modulo 2^16.
  // The low 16 bits of the product stay at or below 65535 / 25 exactly when
  // the year is a multiple of 25.
  localparam logic [15:0] DIV25_INV = 16'd23593;
  localparam logic [15:0] DIV25_MAX = 16'd2621;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [1:0]  zone_sign;
    logic [4:0]  zone_hours;
    logic [5:0]  zone_minutes;
  } ztu_in_t;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic        converted;
  } ztu_out_t;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  // Month length; months outside 1..12 count as 31 days.
  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      4'd2: begin
        len = leap ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        len = 5'd30;
      end
      default: begin
        len = 5'd31;
      end
    endcase
    return len;
  endfunction

  // One day forward. Leap status of the starting year is enough: a year
  // carry always lands in January.
  function automatic date_t step_fwd(input date_t d, input logic leap);
    date_t      r;
    logic [5:0] day_inc;
    r       = d;
    day_inc = {1'b0, d.day} + 6'd1;
    if (day_inc > {1'b0, days_in(d.month, leap)}) begin
      r.day = 5'd1;
      if (d.month >= MONTHS_PER_YEAR) begin
        r.month = 4'd1;
        r.year  = d.year + 16'd1;
      end else begin
        r.month = d.month + 4'd1;
      end
    end else begin
      r.day = day_inc[4:0];
    end
    return r;
  endfunction

  // One day back. A year borrow lands in December, where leap status does
  // not matter.
  function automatic date_t step_back(input date_t d, input logic leap);
    date_t r;
    r = d;
    if (d.day > 5'd1) begin
      r.day = d.day - 5'd1;
    end else begin
      if (d.month > 4'd1) begin
        r.month = d.month - 4'd1;
      end else begin
        r.month = MONTHS_PER_YEAR;
        r.year  = d.year - 16'd1;
      end
      r.day = days_in(r.month, leap);
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/ztu_convert.sv
// Combinational conversion of one zoned date and time to UTC.
`timescale 1ns / 1ps

module ztu_convert (
  input  ztu_pkg::ztu_in_t  item,
  output ztu_pkg::ztu_out_t result
);
  import ztu_pkg::*;

  logic              minus;
  logic signed [7:0] min_raw;
  logic signed [7:0] min_fix;
  logic signed [2:0] min_carry;
  logic signed [7:0] hour_raw;
  logic signed [7:0] hour_fix;
  logic signed [2:0] day_shift;
  logic [15:0]       div25_prod;
  logic              div25;
  logic              leap;
  date_t             d0;
  date_t             f1;
  date_t             f2;
  date_t             b1;
  date_t             b2;
  date_t             dsel;

  assign minus = (item.zone_sign == ZONE_MINUS);

  // The offset is split into a minute part and an hour part; the minute part
  // is normalized first and its carry folds into the hour part.
  always_comb begin
    if (minus) begin
      min_raw = $signed({2'b00, item.minute}) + $signed({2'b00, item.zone_minutes});
    end else begin
      min_raw = $signed({2'b00, item.minute}) - $signed({2'b00, item.zone_minutes});
    end
    priority if (min_raw < -8'sd60) begin
      min_fix   = min_raw + 8'sd120;
      min_carry = -3'sd2;
    end else if (min_raw < 8'sd0) begin
      min_fix   = min_raw + 8'sd60;
      min_carry = -3'sd1;
    end else if (min_raw >= 8'sd120) begin
      min_fix   = min_raw - 8'sd120;
      min_carry = 3'sd2;
    end else if (min_raw >= 8'sd60) begin
      min_fix   = min_raw - 8'sd60;
      min_carry = 3'sd1;
    end else begin
      min_fix   = min_raw;
      min_carry = 3'sd0;
    end
  end

  always_comb begin
    if (minus) begin
      hour_raw = $signed({3'b000, item.hour}) + $signed({3'b000, item.zone_hours})
               + $signed({{5{min_carry[2]}}, min_carry});
    end else begin
      hour_raw = $signed({3'b000, item.hour}) - $signed({3'b000, item.zone_hours})
               + $signed({{5{min_carry[2]}}, min_carry});
    end
    priority if (hour_raw < -8'sd24) begin
      hour_fix  = hour_raw + 8'sd48;
      day_shift = -3'sd2;
    end else if (hour_raw < 8'sd0) begin
      hour_fix  = hour_raw + 8'sd24;
      day_shift = -3'sd1;
    end else if (hour_raw >= 8'sd48) begin
      hour_fix  = hour_raw - 8'sd48;
      day_shift = 3'sd2;
    end else if (hour_raw >= 8'sd24) begin
      hour_fix  = hour_raw - 8'sd24;
      day_shift = 3'sd1;
    end else begin
      hour_fix  = hour_raw;
      day_shift = 3'sd0;
    end
  end

  // Gregorian leap year: a multiple of 4 that is not a multiple of 100,
  // or a multiple of 400 (a multiple of 25 and of 16).
  assign div25_prod = 16'(item.year * DIV25_INV);
  assign div25      = (div25_prod <= DIV25_MAX);
  assign leap       = (item.year[1:0] == 2'b00) && (!div25 || (item.year[3:0] == 4'b0000));

  assign d0 = '{year: item.year, month: item.month, day: item.day};
  assign f1 = step_fwd(d0, leap);
  assign f2 = step_fwd(f1, leap);
  assign b1 = step_back(d0, leap);
  assign b2 = step_back(b1, leap);

  always_comb begin
    unique case (day_shift)
      -3'sd2:  dsel = b2;
      -3'sd1:  dsel = b1;
      3'sd1:   dsel = f1;
      3'sd2:   dsel = f2;
      default: dsel = d0;
    endcase
  end

  always_comb begin
    if (item.zone_sign == ZONE_UTC) begin
      result.year      = item.year;
      result.month     = item.month;
      result.day       = item.day;
      result.hour      = item.hour;
      result.minute    = item.minute;
      result.converted = 1'b0;
    end else begin
      result.year      = dsel.year;
      result.month     = dsel.month;
      result.day       = dsel.day;
      result.hour      = hour_fix[4:0];
      result.minute    = min_fix[5:0];
      result.converted = 1'b1;
    end
  end

endmodule

// File: hw/rtl/zoned_time_to_utc.sv
// Top level of the zoned time to UTC converter: stream ports and the two register stages.
`timescale 1ns / 1ps

// Converts a civil date and time carrying a zone offset into UTC. Each item
// on the slave side holds a date, a time of day and a zone (sign code on
// s_tuser, offset hours and minutes in s_tdata); the offset is subtracted
// from the time of day and the date moves by whole days across midnight,
// with month and year carries and Gregorian leap years. A sign code of zero
// marks the time as already UTC: the item passes through unchanged and the
// converted flag on m_tuser is low. Sign code 3 acts as a positive offset.
// Years wrap modulo 65536. The block takes one item per clock cycle while the
// output is not stalled by m_tready; each accepted item is held first in the
// input register and then in the result register, with the whole conversion
// done by the logic between them. A stage loads whenever it is empty or its
// item moves on in the same cycle. While a finished result waits on m_tready,
// the input register can still take one more item; once both registers are
// full, s_tready follows m_tready within the same cycle.
module zoned_time_to_utc (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // From bit 0: year_in[15:0], month_in[19:16], day_in[24:20], hour_in[29:25],
  // minute_in[35:30], zone_hours[40:36], zone_minutes[46:41], zero pad [47].
  input  logic [47:0] s_tdata,
  // zone_sign[1:0].
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // From bit 0: year_out[15:0], month_out[19:16], day_out[24:20],
  // hour_out[29:25], minute_out[35:30], zero pad [39:36].
  output logic [39:0] m_tdata,
  // converted[0].
  output logic [0:0]  m_tuser
);
  import ztu_pkg::*;

  ztu_in_t  in_item;
  ztu_in_t  in_q;
  logic     in_valid;
  ztu_out_t conv_result;
  ztu_out_t out_q;
  logic     out_valid;
  logic     adv_out;
  logic     adv_in;

  assign in_item.year         = s_tdata[15:0];
  assign in_item.month        = s_tdata[19:16];
  assign in_item.day          = s_tdata[24:20];
  assign in_item.hour         = s_tdata[29:25];
  assign in_item.minute       = s_tdata[35:30];
  assign in_item.zone_sign    = s_tuser;
  assign in_item.zone_hours   = s_tdata[40:36];
  assign in_item.zone_minutes = s_tdata[46:41];

  // A stage may load when it is empty or when its item moves on this cycle.
  assign adv_out  = !out_valid || m_tready;
  assign adv_in   = !in_valid || adv_out;
  assign s_tready = adv_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_in) begin
        in_valid <= s_tvalid;
      end
      if (adv_out) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in && s_tvalid) begin
      in_q <= in_item;
    end
    if (adv_out && in_valid) begin
      out_q <= conv_result;
    end
  end

  ztu_convert u_convert (
    .item   (in_q),
    .result (conv_result)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_q.minute, out_q.hour, out_q.day, out_q.month, out_q.year};
  assign m_tuser  = out_q.converted;

  // A converted result always carries a normalized time of day.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[29:25] < 5'd24 && m_tdata[35:30] < 6'd60))
    else $error("converted result has a time of day out of range");

  // An accepted item occupies the input register on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> in_valid)
    else $error("accepted item lost before the input register");

  // An item leaving the input register shows up as a result.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && adv_out) |=> m_tvalid)
    else $error("item lost between the input and result registers");

endmodule
